/* hw/rtl/tdtp_pkg.sv */
package tdtp_pkg;

    // byte codes seen on the receive stream
    localparam logic [7:0] TAG_X   = 8'h58;  // 'X'
    localparam logic [7:0] TAG_Y   = 8'h59;  // 'Y'
    localparam logic [7:0] TAG_Z   = 8'h5A;  // 'Z'
    localparam logic [7:0] TAG_B   = 8'h42;  // 'B'
    localparam logic [7:0] TAG_V   = 8'h56;  // 'V'
    localparam logic [7:0] TAG_D   = 8'h44;  // 'D'
    localparam logic [7:0] TAG_I   = 8'h49;  // 'I'
    localparam logic [7:0] TERM_CH = 8'h2E;  // '.'

    localparam logic [15:0] DIGIT_BIAS = 16'd48;

    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 3;
    localparam int VALUE_W = 16;

    localparam int MAX_DIGITS_DEF = 4;

    // telemetry field codes
    typedef enum logic [INDEX_W-1:0] {
        FIELD_X         = 3'd0,
        FIELD_Y         = 3'd1,
        FIELD_HEADING   = 3'd2,
        FIELD_DISCHARGE = 3'd3,
        FIELD_VOLTAGE   = 3'd4,
        FIELD_RIGHT_SPD = 3'd5,
        FIELD_LEFT_SPD  = 3'd6
    } field_t;

    typedef struct packed {
        logic   hit;
        field_t field;
    } tag_dec_t;

    // tag letter decode
    function automatic tag_dec_t decode_tag(input logic [BYTE_W-1:0] b);
        tag_dec_t d;
        d.hit   = 1'b1;
        d.field = FIELD_X;
        unique case (b)
            TAG_X:   d.field = FIELD_X;
            TAG_Y:   d.field = FIELD_Y;
            TAG_Z:   d.field = FIELD_HEADING;
            TAG_B:   d.field = FIELD_DISCHARGE;
            TAG_V:   d.field = FIELD_VOLTAGE;
            TAG_D:   d.field = FIELD_RIGHT_SPD;
            TAG_I:   d.field = FIELD_LEFT_SPD;
            default: d.hit   = 1'b0;
        endcase
        return d;
    endfunction

    // wrap a value to the width of its field
    function automatic logic [VALUE_W-1:0] wrap_field(input field_t f,
                                                      input logic [VALUE_W-1:0] v);
        logic [VALUE_W-1:0] r;
        case (f) inside
            FIELD_X, FIELD_Y, FIELD_DISCHARGE, FIELD_VOLTAGE:
                r = {8'h00, v[7:0]};
            default:
                r = v;
        endcase
        return r;
    endfunction

endpackage

/* hw/rtl/tagged_decimal_telemetry_parser_unit.sv */
// path: an accepted byte waits in the input register; a tag or terminator byte then loads
// the result register, which raises m_tvalid, once that register is free
// throughput: one byte per cycle while m_tready stays high; a result waiting in the
// result register holds s_tready low only when the byte in the input register has one too
// reset: synchronous, active low; clears field to x, digit count and accumulator to
// zero, and empties both registers
module tagged_decimal_telemetry_parser_unit
    import tdtp_pkg::*;
#(
    parameter int MaxDigits = MAX_DIGITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    // s_tdata: [7:0] rx_byte
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [BYTE_W-1:0]  s_tdata,
    // m_tdata: [15:0] field_value
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [VALUE_W-1:0] m_tdata,
    // m_tuser: [2:0] field_index
    output logic [INDEX_W-1:0] m_tuser
);

    localparam int CntW = $clog2(MaxDigits + 1);
    localparam logic [CntW-1:0] CntMax = CntW'(MaxDigits);

    // input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    // parser state
    field_t             field_reg,  field_next;
    logic [CntW-1:0]    count_reg,  count_next;
    logic [VALUE_W-1:0] acc_reg,    acc_next;

    // result register
    logic               out_valid_reg;
    field_t             out_index_reg, out_index_next;
    logic [VALUE_W-1:0] out_value_reg, out_value_next;

    tag_dec_t tag;
    logic     is_term;
    logic     has_result;
    logic     out_free;
    logic     advance;
    logic [VALUE_W-1:0] digit_acc;

    // decode and state update for the byte in the input register
    always_comb begin
        tag        = decode_tag(in_byte_reg);
        is_term    = (in_byte_reg == TERM_CH);
        has_result = tag.hit || is_term;
        digit_acc  = (acc_reg << 3) + (acc_reg << 1) + {8'h00, in_byte_reg} - DIGIT_BIAS;

        field_next     = field_reg;
        count_next     = count_reg;
        acc_next       = acc_reg;
        out_index_next = field_reg;
        out_value_next = '0;
        if (tag.hit) begin
            field_next     = tag.field;
            count_next     = '0;
            acc_next       = '0;
            out_index_next = tag.field;
        end else if (is_term) begin
            count_next     = '0;
            acc_next       = '0;
            out_value_next = wrap_field(field_reg, acc_reg);
        end else if (count_reg < CntMax) begin
            acc_next   = digit_acc;
            count_next = count_reg + CntW'(1);
        end
    end

    // handshake
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!has_result || out_free);
    assign s_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    // parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_reg <= FIELD_X;
            count_reg <= '0;
            acc_reg   <= '0;
        end else if (advance) begin
            field_reg <= field_next;
            count_reg <= count_next;
            acc_reg   <= acc_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= advance && has_result;
        end
        if (out_free && advance && has_result) begin
            out_index_reg <= out_index_next;
            out_value_reg <= out_value_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_index_reg;

    // digit count never passes its limit
    a_count_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CntMax)
        else $error("digit count above limit");

    // narrow fields carry no upper byte
    a_narrow_value: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (out_index_reg == FIELD_X || out_index_reg == FIELD_Y ||
            out_index_reg == FIELD_DISCHARGE || out_index_reg == FIELD_VOLTAGE)
        |-> out_value_reg[15:8] == 8'h00)
        else $error("narrow field value has upper bits set");

    // a tag result always carries zero
    a_tag_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && tag.hit && out_free |=> out_valid_reg && out_value_reg == '0)
        else $error("tag result is not zero");

    // a terminator clears the digit state
    a_term_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && is_term |=> count_reg == '0 && acc_reg == '0)
        else $error("terminator left digit state");

    // the state only moves when a byte is consumed
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(acc_reg) && $stable(count_reg) && $stable(field_reg))
        else $error("parser state moved without a byte");

endmodule
